// ===== rtl/rbd_pkg.sv =====
`default_nettype none
package rbd_pkg;

   localparam int DATA_W = 32;
   localparam int MODE_W = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_SIZE       = 3'd4,
      MODE_EMPTY      = 3'd5,
      MODE_PEEK_FRONT = 3'd6,
      MODE_PEEK_BACK  = 3'd7
   } mode_type;

   localparam logic signed [DATA_W-1:0] EMPTY_RESULT = '1;

endpackage
`default_nettype wire

// ===== rtl/rbd_req_if.sv =====
`default_nettype none
interface rbd_req_if import rbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

// ===== rtl/rbd_rsp_if.sv =====
`default_nettype none
interface rbd_rsp_if import rbd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] result_value;
   logic                     was_empty;

   modport source (output valid, output result_value, output was_empty, input ready);
   modport sink   (input valid, input result_value, input was_empty, output ready);
endinterface
`default_nettype wire

// ===== rtl/ring_buffer_deque_unit.sv =====
// ring_buffer_deque_unit: double-ended queue of 32-bit signed values kept in a
// circular memory of DEPTH entries; holds at most DEPTH-1 values.
// req channel: one beat is one command (mode, value). Pushes return nothing;
// a push into a full deque is dropped silently.
// rsp channel: one beat (result_value, was_empty) for every pop, peek, size
// and empty command; a pop or peek on an empty deque returns -1 with
// was_empty set.
// A command with a result passes the pending register (with the registered
// read of the element memory for a pop or peek) and then the output register
// before it shows on rsp. Pushes can be taken back to back; after a command
// with a result, req stays low while it is pending, so no new command is taken
// before its result moves on. A stalled rsp holds its beat and req stays low
// until the waiting beat is taken.
// Reset (synchronous, active high) empties the deque by clearing both
// indexes; the memory contents are not cleared and need no pass.
`default_nettype none
module ring_buffer_deque_unit
   import rbd_pkg::*;
#(
   parameter int DEPTH = 16384
) (
   input wire logic   clock,
   input wire logic   reset,
   rbd_req_if.sink    req,
   rbd_rsp_if.source  rsp
);

   localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);

   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic          pend_ff, pend_in;
   logic          pend_mem_ff, pend_mem_in;
   logic [DATA_W-1:0] pend_res_ff, pend_res_in;
   logic          pend_flag_ff, pend_flag_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_empty_ff, rsp_empty_in;

   logic          fire;
   mode_type      mode;
   logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
   logic          is_empty, is_full;
   logic [AW:0]   size_val;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign back_inc  = (back_ff == LAST_IDX) ? '0 : back_ff + 1'b1;
   assign back_dec  = (back_ff == '0) ? LAST_IDX : back_ff - 1'b1;
   assign is_empty  = (front_ff == back_ff);
   assign is_full   = (back_inc == front_ff);
   assign size_val  = (back_ff >= front_ff) ? {1'b0, back_ff} - {1'b0, front_ff}
                                            : {1'b0, back_ff} + DEPTH_W - {1'b0, front_ff};

   assign req.ready = !pend_ff && (!rsp_valid_ff || rsp.ready);
   assign fire      = req.valid && req.ready;
   assign mode      = mode_type'(req.mode);

   always_comb begin
      front_in     = front_ff;
      back_in      = back_ff;
      pend_in      = 1'b0;
      pend_mem_in  = 1'b0;
      pend_res_in  = pend_res_ff;
      pend_flag_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = back_ff;
      rd_en        = 1'b0;
      rd_addr      = front_ff;
      if (fire) begin
         pend_res_in = EMPTY_RESULT;
         unique case (mode)
            MODE_PUSH_FRONT: begin
               if (!is_full) begin
                  wr_en    = 1'b1;
                  wr_addr  = front_dec;
                  front_in = front_dec;
               end
            end
            MODE_PUSH_BACK: begin
               if (!is_full) begin
                  wr_en   = 1'b1;
                  back_in = back_inc;
               end
            end
            MODE_POP_FRONT, MODE_PEEK_FRONT: begin
               pend_in      = 1'b1;
               pend_flag_in = is_empty;
               if (!is_empty) begin
                  rd_en       = 1'b1;
                  pend_mem_in = 1'b1;
                  if (mode == MODE_POP_FRONT) begin
                     front_in = front_inc;
                  end
               end
            end
            MODE_POP_BACK, MODE_PEEK_BACK: begin
               pend_in      = 1'b1;
               pend_flag_in = is_empty;
               if (!is_empty) begin
                  rd_en       = 1'b1;
                  rd_addr     = back_dec;
                  pend_mem_in = 1'b1;
                  if (mode == MODE_POP_BACK) begin
                     back_in = back_dec;
                  end
               end
            end
            MODE_SIZE: begin
               pend_in     = 1'b1;
               pend_res_in = DATA_W'(size_val);
            end
            MODE_EMPTY: begin
               pend_in     = 1'b1;
               pend_res_in = DATA_W'(is_empty);
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_empty_in = rsp_empty_ff;
      if (pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = pend_mem_ff ? rd_data : pend_res_ff;
         rsp_empty_in = pend_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         back_ff      <= back_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_mem_ff  <= pend_mem_in;
      pend_res_ff  <= pend_res_in;
      pend_flag_ff <= pend_flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   rbd_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.result_value = rsp_value_ff;
   assign rsp.was_empty    = rsp_empty_ff;

endmodule
`default_nettype wire

// ===== rtl/rbd_store.sv =====
`default_nettype none
module rbd_store
   import rbd_pkg::*;
#(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire
